>>> src/npe_pkg.sv
// ----------------------------------------------------------------------------
// npe_pkg
// Shared types, constants and tables for the NMEA position extractor.
// ----------------------------------------------------------------------------
package npe_pkg;

    localparam int LINE_DEPTH      = 128;
    localparam int FRACTION_DIGITS = 5;

    localparam int CODE_W   = 30;
    localparam int NUM_W    = 64;
    localparam int DEN_W    = 33;
    localparam int REM_W    = DEN_W + 1;
    localparam int PROD_W   = 43;
    localparam int SCALE_W  = 27;
    localparam int CNT_W    = 5;
    localparam int SCALE_STEPS = 12;

    localparam logic [9:0]  DEG_MAX  = 10'd1023;
    localparam logic [6:0]  MIN_MAX  = 7'd127;
    localparam logic [26:0] FRAC_MAX = 27'h7FFFFFF;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_L      = 8'h4C;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_C      = 8'h43;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_GGA  = 2'd1;
    localparam logic [1:0] KIND_GLL  = 2'd2;
    localparam logic [1:0] KIND_RMC  = 2'd3;

    localparam logic [8:0] ORDER_NONE = 9'h1FF;

    typedef struct packed {
        logic take;
        logic load_prod;
        logic load_num;
        logic scale_step;
        logic div_init;
        logic div_step;
        logic apply;
    } npe_cmd_t;

    typedef struct packed {
        logic need_conv;
    } npe_status_t;

    function automatic logic [SCALE_W-1:0] pow_ten(input logic [3:0] k);
        case (k)
            4'd0:    pow_ten = 27'd1;
            4'd1:    pow_ten = 27'd10;
            4'd2:    pow_ten = 27'd100;
            4'd3:    pow_ten = 27'd1000;
            4'd4:    pow_ten = 27'd10000;
            4'd5:    pow_ten = 27'd100000;
            4'd6:    pow_ten = 27'd1000000;
            4'd7:    pow_ten = 27'd10000000;
            default: pow_ten = 27'd100000000;
        endcase
    endfunction

    function automatic logic [DEN_W-1:0] den_tab(input logic [3:0] k);
        case (k)
            4'd0:    den_tab = 33'd60;
            4'd1:    den_tab = 33'd600;
            4'd2:    den_tab = 33'd6000;
            4'd3:    den_tab = 33'd60000;
            4'd4:    den_tab = 33'd600000;
            4'd5:    den_tab = 33'd6000000;
            4'd6:    den_tab = 33'd60000000;
            4'd7:    den_tab = 33'd600000000;
            default: den_tab = 33'd6000000000;
        endcase
    endfunction

    // 10^8 * den
    function automatic logic [NUM_W-1:0] limit_tab(input logic [3:0] k);
        case (k)
            4'd0:    limit_tab = 64'd6000000000;
            4'd1:    limit_tab = 64'd60000000000;
            4'd2:    limit_tab = 64'd600000000000;
            4'd3:    limit_tab = 64'd6000000000000;
            4'd4:    limit_tab = 64'd60000000000000;
            4'd5:    limit_tab = 64'd600000000000000;
            4'd6:    limit_tab = 64'd6000000000000000;
            4'd7:    limit_tab = 64'd60000000000000000;
            default: limit_tab = 64'd600000000000000000;
        endcase
    endfunction

    function automatic logic [8:0] lat_order(input logic [1:0] kind);
        case (kind)
            KIND_GGA: lat_order = 9'd2;
            KIND_GLL: lat_order = 9'd1;
            KIND_RMC: lat_order = 9'd3;
            default:  lat_order = ORDER_NONE;
        endcase
    endfunction

    function automatic logic [8:0] lon_order(input logic [1:0] kind);
        case (kind)
            KIND_GGA: lon_order = 9'd4;
            KIND_GLL: lon_order = 9'd3;
            KIND_RMC: lon_order = 9'd5;
            default:  lon_order = ORDER_NONE;
        endcase
    endfunction

endpackage

>>> src/nmea_position_extractor.sv
// ----------------------------------------------------------------------------
// nmea_position_extractor
// NMEA GGA/GLL/RMC sentence parser giving 9-digit latitude/longitude codes.
// ----------------------------------------------------------------------------
// One character per item, one result per item. A comma in a GGA, GLL or RMC
// sentence whose longitude field is not yet closed is converted between
// acceptance and result: 12 scaling steps of the 64-bit numerator and a
// 30-step radix-2 divide by the 60*10^k denominator, k the fraction digits.
// Any other character skips the conversion. A new item is accepted only
// when idle and no result waits, or it is taken in the same cycle.
module nmea_position_extractor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  char_in,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        fix_found,
    output logic [29:0] latitude_code,
    output logic [29:0] longitude_code,
    output logic        out_valid,
    input  logic        out_ready
);
    import npe_pkg::*;

    npe_cmd_t    cmd;
    npe_status_t status;

    npe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    npe_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .char_in        (char_in),
        .cmd            (cmd),
        .status         (status),
        .fix_found      (fix_found),
        .latitude_code  (latitude_code),
        .longitude_code (longitude_code)
    );

endmodule

>>> src/npe_ctrl.sv
// ----------------------------------------------------------------------------
// npe_ctrl
// Sequencer: handshakes, conversion steps and result slot.
// ----------------------------------------------------------------------------
module npe_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  npe_pkg::npe_status_t status,
    output npe_pkg::npe_cmd_t    cmd
);
    import npe_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_EVAL, S_LOAD, S_ADD, S_SCALE, S_DINIT, S_DIV, S_FIN
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               out_valid_reg;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.take       = in_valid && in_ready;
        cmd.load_prod  = (state_reg == S_LOAD);
        cmd.load_num   = (state_reg == S_ADD);
        cmd.scale_step = (state_reg == S_SCALE);
        cmd.div_init   = (state_reg == S_DINIT);
        cmd.div_step   = (state_reg == S_DIV);
        cmd.apply      = (state_reg == S_FIN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                        state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    state_reg <= status.need_conv ? S_LOAD : S_FIN;
                end
                S_LOAD:
                begin
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(SCALE_STEPS - 1))
                        state_reg <= S_DINIT;
                end
                S_DINIT:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(CODE_W - 1))
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> src/npe_datapath.sv
// ----------------------------------------------------------------------------
// npe_datapath
// Sentence parser state, coordinate conversion and result registers.
// ----------------------------------------------------------------------------
module npe_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            char_in,
    input  npe_pkg::npe_cmd_t     cmd,
    output npe_pkg::npe_status_t  status,
    output logic                  fix_found,
    output logic [29:0]           latitude_code,
    output logic [29:0]           longitude_code
);
    import npe_pkg::*;

    logic [7:0]   char_reg;
    logic         end_reg;
    logic [7:0]   count_reg,  count_next;
    logic [7:0]   field_reg,  field_next;
    logic [1:0]   kind_reg,   kind_next;
    logic         start_reg,  start_next;
    logic [19:0]  hist_reg,   hist_next;
    logic [9:0]   deg_reg,    deg_next;
    logic [6:0]   min_reg,    min_next;
    logic [26:0]  frac_reg,   frac_next;
    logic [3:0]   fcnt_reg,   fcnt_next;
    logic         point_reg,  point_next;
    logic         closed_reg, closed_next;
    logic [29:0]  stlat_reg,  stlat_next;
    logic [29:0]  stlon_reg,  stlon_next;
    logic [29:0]  plat_reg,   plat_next;
    logic [29:0]  plon_reg,   plon_next;
    logic         plat_ok_reg, plat_ok_next;
    logic         plon_ok_reg, plon_ok_next;
    logic         fix_reg,    fix_next;
    logic [29:0]  lat_out_reg;
    logic [29:0]  lon_out_reg;

    logic [PROD_W-1:0]  prod_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [CODE_W-1:0]  quo_reg;

    logic [3:0]         k;
    logic [DEN_W-1:0]   den;
    logic [REM_W:0]     trial;
    logic               trial_ge;
    logic [16:0]        whole;

    logic [7:0]   c;
    logic [3:0]   nib;
    logic [17:0]  d;
    logic [10:0]  m;
    logic [31:0]  f;
    logic [8:0]   fidx;
    logic         take_end;
    logic [1:0]   kind_take;
    logic         start_take;

    assign k     = (fcnt_reg > 4'd8) ? 4'd8 : fcnt_reg;
    assign den   = den_tab(k);
    assign whole = 17'(deg_reg) * 17'd60 + 17'(min_reg);
    assign trial = {1'b0, rem_reg[REM_W-2:0], quo_reg[CODE_W-1]};
    assign trial_ge = trial >= (REM_W+1)'(den);

    assign status.need_conv = !end_reg && !closed_reg && (char_reg == CH_COMMA)
                              && (kind_reg != KIND_NONE);

    assign fix_found      = fix_reg;
    assign latitude_code  = lat_out_reg;
    assign longitude_code = lon_out_reg;

    // start / kind tracking on the incoming character
    always_comb
    begin
        take_end   = (count_reg >= 8'(LINE_DEPTH)) || (char_in == CH_NL);
        start_take = start_reg;
        kind_take  = kind_reg;
        if (count_reg == 8'd0)
            start_take = (char_in == CH_DOLLAR);
        if (count_reg >= 8'd3 && count_reg <= 8'd5)
        begin
            if (!start_reg)
                kind_take = KIND_NONE;
            else if (count_reg == 8'd3)
                kind_take = (char_in == CH_G) ? KIND_GGA :
                            (char_in == CH_R) ? KIND_RMC : KIND_NONE;
            else if (count_reg == 8'd4)
            begin
                if (kind_reg == KIND_GGA)
                    kind_take = (char_in == CH_G) ? KIND_GGA :
                                (char_in == CH_L) ? KIND_GLL : KIND_NONE;
                else if (kind_reg == KIND_RMC)
                    kind_take = (char_in == CH_M) ? KIND_RMC : KIND_NONE;
                else
                    kind_take = KIND_NONE;
            end
            else if (!((kind_reg == KIND_GGA && char_in == CH_A) ||
                       (kind_reg == KIND_GLL && char_in == CH_L) ||
                       (kind_reg == KIND_RMC && char_in == CH_C)))
                kind_take = KIND_NONE;
        end
    end

    // rest of the step, applied once conversion (if any) is done
    always_comb
    begin
        c    = char_reg;
        nib  = char_reg[3:0];
        fidx = {1'b0, field_reg};
        d    = '0;
        m    = '0;
        f    = '0;
        count_next   = count_reg;
        field_next   = field_reg;
        kind_next    = kind_reg;
        start_next   = start_reg;
        hist_next    = hist_reg;
        deg_next     = deg_reg;
        min_next     = min_reg;
        frac_next    = frac_reg;
        fcnt_next    = fcnt_reg;
        point_next   = point_reg;
        closed_next  = closed_reg;
        stlat_next   = stlat_reg;
        stlon_next   = stlon_reg;
        plat_next    = plat_reg;
        plon_next    = plon_reg;
        plat_ok_next = plat_ok_reg;
        plon_ok_next = plon_ok_reg;
        fix_next     = 1'b0;
        if (end_reg)
        begin
            if (count_reg >= 8'd6 && kind_reg != KIND_NONE)
            begin
                if (plat_ok_reg)
                    stlat_next = plat_reg;
                if (plon_ok_reg)
                begin
                    stlon_next = plon_reg;
                    fix_next   = 1'b1;
                end
            end
            count_next   = '0;
            field_next   = '0;
            kind_next    = KIND_NONE;
            start_next   = 1'b0;
            hist_next    = '0;
            closed_next  = 1'b0;
            plat_next    = '0;
            plon_next    = '0;
            plat_ok_next = 1'b0;
            plon_ok_next = 1'b0;
            deg_next     = '0;
            min_next     = '0;
            frac_next    = '0;
            fcnt_next    = '0;
            point_next   = 1'b0;
        end
        else
        begin
            if (!closed_reg)
            begin
                if (c == CH_COMMA)
                begin
                    if (kind_reg != KIND_NONE && quo_reg != '0)
                    begin
                        if (fidx == lat_order(kind_reg))
                        begin
                            plat_next    = quo_reg;
                            plat_ok_next = 1'b1;
                        end
                        else if (fidx == lon_order(kind_reg))
                        begin
                            plon_next    = quo_reg;
                            plon_ok_next = 1'b1;
                            closed_next  = 1'b1;
                        end
                    end
                    deg_next   = '0;
                    min_next   = '0;
                    frac_next  = '0;
                    fcnt_next  = '0;
                    point_next = 1'b0;
                    if (field_reg != 8'd255)
                        field_next = field_reg + 8'd1;
                end
                else if (c == CH_POINT)
                begin
                    if (fidx == lon_order(kind_reg))
                    begin
                        d = (18'(deg_reg) + 18'(hist_reg[19:16])) * 18'd10
                            + 18'(hist_reg[15:12]);
                        d = d * 18'd10 + 18'(hist_reg[11:8]);
                    end
                    else
                        d = (18'(deg_reg) + 18'(hist_reg[15:12])) * 18'd10
                            + 18'(hist_reg[11:8]);
                    deg_next = (d > 18'(DEG_MAX)) ? DEG_MAX : d[9:0];
                    m = (11'(min_reg) + 11'(hist_reg[7:4])) * 11'd10
                        + 11'(hist_reg[3:0]);
                    min_next   = (m > 11'(MIN_MAX)) ? MIN_MAX : m[6:0];
                    point_next = 1'b1;
                end
                else if (point_reg && fcnt_reg < 4'(FRACTION_DIGITS))
                begin
                    f = 32'(frac_reg) * 32'd10 + 32'(nib);
                    frac_next = (f > 32'(FRAC_MAX)) ? FRAC_MAX : f[26:0];
                    fcnt_next = fcnt_reg + 4'd1;
                end
            end
            hist_next  = {hist_reg[15:0], nib};
            count_next = count_reg + 8'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
            char_reg <= char_in;
        if (cmd.load_prod)
            prod_reg <= PROD_W'(whole) * PROD_W'(pow_ten(k));
        if (cmd.load_num)
            num_reg <= NUM_W'(prod_reg) + NUM_W'(frac_reg);
        if (cmd.scale_step && num_reg < limit_tab(k))
            num_reg <= (num_reg << 3) + (num_reg << 1);
        if (cmd.div_init)
        begin
            rem_reg <= num_reg[NUM_W-1:CODE_W];
            quo_reg <= num_reg[CODE_W-1:0];
        end
        if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? REM_W'(trial - (REM_W+1)'(den)) : REM_W'(trial);
            quo_reg <= {quo_reg[CODE_W-2:0], trial_ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_reg     <= 1'b0;
            count_reg   <= '0;
            field_reg   <= '0;
            kind_reg    <= KIND_NONE;
            start_reg   <= 1'b0;
            hist_reg    <= '0;
            deg_reg     <= '0;
            min_reg     <= '0;
            frac_reg    <= '0;
            fcnt_reg    <= '0;
            point_reg   <= 1'b0;
            closed_reg  <= 1'b0;
            stlat_reg   <= '0;
            stlon_reg   <= '0;
            plat_reg    <= '0;
            plon_reg    <= '0;
            plat_ok_reg <= 1'b0;
            plon_ok_reg <= 1'b0;
            fix_reg     <= 1'b0;
            lat_out_reg <= '0;
            lon_out_reg <= '0;
        end
        else if (cmd.take)
        begin
            end_reg <= take_end;
            if (!take_end)
            begin
                start_reg <= start_take;
                kind_reg  <= kind_take;
            end
        end
        else if (cmd.apply)
        begin
            count_reg   <= count_next;
            field_reg   <= field_next;
            kind_reg    <= kind_next;
            start_reg   <= start_next;
            hist_reg    <= hist_next;
            deg_reg     <= deg_next;
            min_reg     <= min_next;
            frac_reg    <= frac_next;
            fcnt_reg    <= fcnt_next;
            point_reg   <= point_next;
            closed_reg  <= closed_next;
            stlat_reg   <= stlat_next;
            stlon_reg   <= stlon_next;
            plat_reg    <= plat_next;
            plon_reg    <= plon_next;
            plat_ok_reg <= plat_ok_next;
            plon_ok_reg <= plon_ok_next;
            fix_reg     <= fix_next;
            lat_out_reg <= stlat_next;
            lon_out_reg <= stlon_next;
        end
    end

endmodule
